// ----- rtl/core/sync_xor_frame_deframer_top_assert.svh -----
// Assertion macros for the sync/XOR frame deframer checker.
`ifndef SYNC_XOR_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_XOR_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SXD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sxd_pkg.sv -----
// Shared constants and types for the sync/XOR frame deframer.
package sxd_pkg;

	localparam logic [7:0] SYNC_FIRST      = 8'hAA;
	localparam logic [7:0] SYNC_SECOND     = 8'h33;
	localparam logic [7:0] LENGTH_AT_RESET = 8'd134;

	// Result event codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PAYLOAD = 2'd1;
	localparam logic [1:0] EV_ACCEPT  = 2'd2;
	localparam logic [1:0] EV_REJECT  = 2'd3;

	// Frame phase codes
	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_SYNC2   = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_CHK_HI  = 3'd3;
	localparam logic [2:0] PH_CHK_LO  = 3'd4;

	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] payload_byte;
		logic       payload_last;
	} sxd_result_t;

endpackage

// ----- rtl/core/sxd_fsm.sv -----
// Frame state machine: sync hunt, payload count, XOR check and trailer compare.
module sxd_fsm import sxd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  frame_len,
	output sxd_result_t result
);

	logic [2:0] phase_q, phase_d;
	logic [7:0] xor_sum_q, xor_sum_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [7:0] check_high_q, check_high_d;
	logic [7:0] count_inc;

	assign count_inc = byte_count_q + 8'd1;

	// Work out the next state and the result for the byte at hand
	always_comb begin
		phase_d      = phase_q;
		xor_sum_d    = xor_sum_q;
		byte_count_d = byte_count_q;
		check_high_d = check_high_q;
		result       = '{event_res: EV_NONE, payload_byte: 8'd0, payload_last: 1'b0};
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == SYNC_FIRST) begin
					phase_d   = PH_SYNC2;
					xor_sum_d = xor_sum_q ^ rx_byte;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d      = PH_PAYLOAD;
					byte_count_d = 8'd0;
					xor_sum_d    = xor_sum_q ^ rx_byte;
				end else begin
					// drop back to hunting; this byte is not rechecked
					phase_d   = PH_HUNT;
					xor_sum_d = 8'd0;
				end
			end
			PH_PAYLOAD: begin
				xor_sum_d           = xor_sum_q ^ rx_byte;
				byte_count_d        = count_inc;
				result.event_res    = EV_PAYLOAD;
				result.payload_byte = rx_byte;
				if (count_inc == frame_len) begin
					phase_d             = PH_CHK_HI;
					result.payload_last = 1'b1;
				end
			end
			PH_CHK_HI: begin
				check_high_d = rx_byte;
				phase_d      = PH_CHK_LO;
			end
			PH_CHK_LO: begin
				if (check_high_q == xor_sum_q && rx_byte == 8'd0) begin
					result.event_res = EV_ACCEPT;
				end else begin
					result.event_res = EV_REJECT;
				end
				// re-examine the low trailer byte as a first sync byte
				if (rx_byte == SYNC_FIRST) begin
					phase_d   = PH_SYNC2;
					xor_sum_d = rx_byte;
				end else begin
					phase_d   = PH_HUNT;
					xor_sum_d = 8'd0;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Advance the state once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			xor_sum_q    <= 8'd0;
			byte_count_q <= 8'd0;
			check_high_q <= 8'd0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			xor_sum_q    <= xor_sum_d;
			byte_count_q <= byte_count_d;
			check_high_q <= check_high_d;
		end
	end

endmodule

// ----- rtl/core/sync_xor_frame_deframer_top.sv -----
// Sync/XOR frame deframer: top level with input, output and length registers.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries one received byte per
//   transaction. Output channel (out_valid, out_stall, event_res, payload_byte,
//   payload_last) carries exactly one result per input byte, in order.
//   event_res: 0 nothing, 1 payload byte, 2 frame accepted, 3 checksum rejected.
//   cfg_wr_en/cfg_wr_data write the payload length (0 means 256 bytes); write
//   it only while the block holds no byte.
// Path: an accepted byte passes through the input register, then the result
//   register, where its result waits until the receiver takes it.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   frame state machine between the two registers.
// Reset: clears both registers' valid flags, returns the machine to sync hunt
//   with a zero XOR sum and loads a payload length of 134.
// Stall: a stalled result holds; the input register still fills behind it,
//   and in_stall rises only when both the input and result registers are full.
module sync_xor_frame_deframer_top import sxd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [7:0] payload_byte,
	output logic       payload_last,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        out_valid_q;
	sxd_result_t result_q;
	sxd_result_t step_result;
	logic        out_load;
	logic        advance;
	logic [7:0]  frame_len_q;

	assign out_load = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_load;
	assign in_stall = valid_s1 && !out_load;

	// Hold the configured payload length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= LENGTH_AT_RESET;
		end else if (cfg_wr_en) begin
			frame_len_q <= cfg_wr_data;
		end
	end

	// Input register: take a transaction whenever the stage is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sxd_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.rx_byte   (rx_byte_s1),
		.frame_len (frame_len_q),
		.result    (step_result)
	);

	// Result register: load when empty or when the receiver takes the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = result_q.event_res;
	assign payload_byte = result_q.payload_byte;
	assign payload_last = result_q.payload_last;

endmodule

// ----- rtl/core/sxd_checker.sv -----
// Port-level checker for the sync/XOR frame deframer, bound to the top level.
`include "sync_xor_frame_deframer_top_assert.svh"

module sxd_checker import sxd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] event_res,
	input logic [7:0] payload_byte,
	input logic       payload_last
);

	logic frame_end;
	assign frame_end = out_valid && (event_res == EV_ACCEPT || event_res == EV_REJECT);

	// Payload fields are zero unless the event is a payload byte
	`SXD_ASSERT_NOW(a_payload_zero, clk, arst_n, out_valid && event_res != EV_PAYLOAD, payload_byte == 8'd0 && !payload_last, "payload fields set on a non-payload event")

	// An empty result register never back-pressures the input
	`SXD_ASSERT_NOW(a_no_stall_when_empty, clk, arst_n, !out_valid, !in_stall, "input stalled while no result is waiting")

	// A frame verdict is never directly followed by another verdict
	`SXD_ASSERT_NEXT(a_no_double_verdict, clk, arst_n, frame_end && !out_stall, !frame_end, "two frame verdicts in consecutive transactions")

	// A stalled result holds its payload
	`SXD_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(event_res) && $stable(payload_byte) && $stable(payload_last), "stalled result changed")

endmodule

bind sync_xor_frame_deframer_top sxd_checker u_sxd_checker (.*);

// ----- dv/sync_xor_frame_deframer_top_test.sv -----
// Self-checking testbench for the sync/XOR frame deframer top level.
`timescale 1ns / 100ps

module sync_xor_frame_deframer_top_test import sxd_pkg::*;;

	localparam int CYCLE_LIMIT = 100000;
	localparam int LONG_HOLD   = 80;

	typedef enum int {
		TRAILER_GOOD,
		TRAILER_BAD_SUM,
		TRAILER_BAD_LOW,
		TRAILER_LOW_SYNC
	} trailer_kind_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] xor_sum;
		logic [7:0] byte_count;
		logic [7:0] check_high;
		logic [7:0] length;
	} frame_state_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] event_res;
	logic [7:0] payload_byte;
	logic       payload_last;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;

	logic [7:0]   bytes_to_send[$];
	sxd_result_t  expected_results[$];
	frame_state_t pred_state;
	frame_state_t gen_state;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  cycle_count = 0;
	int  pushed = 0;
	int  mismatches = 0;
	int  bytes_taken = 0;
	int  payload_seen = 0;
	int  frames_ok = 0;
	int  frames_bad = 0;
	int  input_stalls = 0;

	sync_xor_frame_deframer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.payload_byte (payload_byte),
		.payload_last (payload_last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #10 clk = ~clk;

	function automatic frame_state_t state_after_reset();
		frame_state_t st;
		st.phase      = PH_HUNT;
		st.xor_sum    = 8'h00;
		st.byte_count = 8'h00;
		st.check_high = 8'h00;
		st.length     = LENGTH_AT_RESET;
		return st;
	endfunction

	// Start a frame on the first sync byte, folding it into the sum
	function automatic void arm_on_sync(inout frame_state_t st, input logic [7:0] b);
		st.phase = PH_HUNT;
		if (b == SYNC_FIRST) begin
			st.phase   = PH_SYNC2;
			st.xor_sum = st.xor_sum ^ b;
		end
	endfunction

	// Advance the deframer by one byte and return the result it produces
	function automatic sxd_result_t deframe_step(inout frame_state_t st, input logic [7:0] b);
		sxd_result_t r;
		r.event_res    = EV_NONE;
		r.payload_byte = 8'h00;
		r.payload_last = 1'b0;
		case (st.phase)
		PH_HUNT:
			arm_on_sync(st, b);
		PH_SYNC2: begin
			if (b == SYNC_SECOND) begin
				st.phase      = PH_PAYLOAD;
				st.byte_count = 8'h00;
				st.xor_sum    = st.xor_sum ^ b;
			end else begin
				st.phase   = PH_HUNT;
				st.xor_sum = 8'h00;
			end
		end
		PH_PAYLOAD: begin
			st.xor_sum     = st.xor_sum ^ b;
			st.byte_count  = st.byte_count + 8'd1;
			r.event_res    = EV_PAYLOAD;
			r.payload_byte = b;
			if (st.byte_count == st.length) begin
				st.phase       = PH_CHK_HI;
				r.payload_last = 1'b1;
			end
		end
		PH_CHK_HI: begin
			st.check_high = b;
			st.phase      = PH_CHK_LO;
		end
		PH_CHK_LO: begin
			r.event_res = (st.check_high == st.xor_sum && b == 8'h00) ? EV_ACCEPT : EV_REJECT;
			st.xor_sum  = 8'h00;
			arm_on_sync(st, b);
		end
		default: ;
		endcase
		return r;
	endfunction

	// Random byte, leaning towards the sync values
	function automatic logic [7:0] any_byte();
		case ($urandom_range(7))
		0: return SYNC_FIRST;
		1: return SYNC_SECOND;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Queue a byte for the sender, tracking the frame state it leads to
	task automatic offer(input logic [7:0] b);
		void'(deframe_step(gen_state, b));
		bytes_to_send.push_back(b);
		pushed++;
	endtask

	// Complete a frame from wherever the stream stands, with the chosen trailer
	task automatic push_frame(input trailer_kind_t kind);
		logic [7:0] hi;
		logic [7:0] lo;
		if (gen_state.phase == PH_HUNT)
			offer(SYNC_FIRST);
		if (gen_state.phase == PH_SYNC2)
			offer(SYNC_SECOND);
		while (gen_state.phase == PH_PAYLOAD)
			offer(any_byte());
		hi = gen_state.xor_sum;
		lo = 8'h00;
		case (kind)
		TRAILER_BAD_SUM:  hi = hi ^ 8'($urandom_range(255, 1));
		TRAILER_BAD_LOW:  lo = 8'($urandom_range(255, 1));
		TRAILER_LOW_SYNC: lo = SYNC_FIRST;
		default: ;
		endcase
		if (gen_state.phase == PH_CHK_HI)
			offer(hi);
		if (gen_state.phase == PH_CHK_LO)
			offer(lo);
	endtask

	// Mostly whole frames with random content, some broken sync and line noise
	task automatic random_burst(input int budget);
		int stop_at;
		int pick;
		logic [7:0] b;
		stop_at = pushed + budget;
		while (pushed < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60)
				push_frame(TRAILER_GOOD);
			else if (pick < 70)
				push_frame(TRAILER_BAD_SUM);
			else if (pick < 77)
				push_frame(TRAILER_BAD_LOW);
			else if (pick < 82)
				push_frame(TRAILER_LOW_SYNC);
			else if (pick < 90) begin
				if (gen_state.phase == PH_HUNT)
					offer(SYNC_FIRST);
				if (gen_state.phase == PH_SYNC2) begin
					do
						b = any_byte();
					while (b == SYNC_SECOND);
					offer(b);
				end
			end else begin
				repeat ($urandom_range(4, 1))
					offer(any_byte());
			end
		end
	endtask

	// Wait until the sender has drained and every result has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (bytes_to_send.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic set_length(input logic [7:0] len);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		pred_state.length = len;
		gen_state.length  = len;
	endtask

	// Sender: predict each accepted byte, then offer the next one or idle
	always @(posedge clk) begin : drive_bytes
		logic take;
		take = in_valid && !in_stall;
		if (take) begin
			expected_results.push_back(deframe_step(pred_state, rx_byte));
			bytes_taken++;
		end
		if (in_valid && in_stall)
			input_stalls++;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || take) begin
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte  <= bytes_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver pacing: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check each delivered result against the oldest prediction
	always @(posedge clk) begin : check_results
		sxd_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: event_res %0d payload_byte %02h payload_last %0b",
					event_res, payload_byte, payload_last);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, event_res);
					mismatches++;
				end
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %02h, got %02h", want.payload_byte, payload_byte);
					mismatches++;
				end
				if (payload_last !== want.payload_last) begin
					$error("payload_last: expected %0b, got %0b", want.payload_last, payload_last);
					mismatches++;
				end
				case (want.event_res)
				EV_PAYLOAD: payload_seen++;
				EV_ACCEPT:  frames_ok++;
				EV_REJECT:  frames_bad++;
				default: ;
				endcase
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sync_xor_frame_deframer_top regression: fail");
			$finish;
		end
	end

	initial begin
		pred_state = state_after_reset();
		gen_state  = state_after_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at one payload byte; sender 28 %, receiver 50 %
		send_idle_pct = 28;
		recv_idle_pct = 50;
		set_length(8'd1);
		offer(8'h00);
		offer(8'hFF);
		// a repeated first sync byte drops the hunt and is not taken as a new start
		offer(SYNC_FIRST);
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		offer(8'hFF);
		offer(gen_state.xor_sum);
		offer(8'h00);
		// trailer low byte is a sync byte: rejected, then it opens the next frame
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		offer(8'h00);
		offer(gen_state.xor_sum);
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		offer(8'h5A);
		offer(gen_state.xor_sum);
		offer(8'h00);
		// wrong sum in the trailer high byte
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		offer(8'h12);
		offer(8'h00);
		offer(8'h00);
		wait_idle();

		// Short frames, with a long receiver hold-off and a sender pause
		set_length(8'd3);
		random_burst(25);
		hold_req = 1'b1;
		random_burst(15);
		wait_idle();
		random_burst(10);
		wait_idle();

		// Sender 50 %, receiver 28 %
		send_idle_pct = 50;
		recv_idle_pct = 28;
		set_length(8'd7);
		random_burst(30);
		wait_idle();

		// No idling from here on
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_length(8'd2);
		random_burst(20);
		wait_idle();

		// Longest length: zero counts 256 bytes
		set_length(8'd0);
		push_frame(TRAILER_GOOD);
		wait_idle();

		// Length rewritten mid-frame, first ahead of the count, then behind it
		set_length(8'd20);
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		repeat (3)
			offer(any_byte());
		wait_idle();
		set_length(8'd6);
		push_frame(TRAILER_GOOD);
		wait_idle();
		set_length(8'd20);
		offer(SYNC_FIRST);
		offer(SYNC_SECOND);
		repeat (10)
			offer(any_byte());
		wait_idle();
		set_length(8'd9);
		push_frame(TRAILER_GOOD);
		wait_idle();

		set_length(8'd1);
		random_burst(10);
		wait_idle();
		repeat (4) @(posedge clk);

		$display("Bytes taken %0d, payload bytes %0d, frames accepted %0d, rejected %0d.",
			bytes_taken, payload_seen, frames_ok, frames_bad);
		$display("Payloads of 1 to 256 bytes, mid-frame rewrites; %0d input stall cycles seen.",
			input_stalls);
		if (mismatches == 0)
			$display("sync_xor_frame_deframer_top regression: pass");
		else
			$display("sync_xor_frame_deframer_top regression: fail");
		$finish;
	end

endmodule
